// ----- sv/contiguous_page_allocator_defines.svh -----
// Assertion macros shared by the allocator RTL.
`ifndef CONTIGUOUS_PAGE_ALLOCATOR_DEFINES_SVH
`define CONTIGUOUS_PAGE_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, held off while reset is asserted.
`define CPA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define CPA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/cpa_pkg.sv -----
// Constants and codes shared by the page allocator files.
`timescale 1ns / 1ps
package cpa_pkg;
    localparam int NUM_PAGES   = 1024;
    localparam int PAGE_W      = $clog2(NUM_PAGES);
    localparam int PTR_W       = PAGE_W + 1;
    localparam int WORD_W      = 8;
    localparam int WBIT_W      = $clog2(WORD_W);
    localparam int NUM_WORDS   = NUM_PAGES / WORD_W;
    localparam int WADDR_W     = PAGE_W - WBIT_W;
    localparam int COUNT_W     = 11;
    localparam int SPAGE_W     = 10;
    localparam int GRANT_W     = 10;
    localparam int STATUS_W    = 2;
    localparam int FIT_W       = 2;
    localparam int CHK_W       = (PTR_W > COUNT_W + 1) ? PTR_W : COUNT_W + 1;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOFIT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTUSED = 2'd3;

    localparam logic [FIT_W-1:0] FIT_NEXT = 2'd1;
    localparam logic [FIT_W-1:0] FIT_BEST = 2'd2;

    localparam logic REQ_FREE = 1'b1;
endpackage

// ----- sv/cpa_if.sv -----
// Request and response channel interfaces of the page allocator.
`timescale 1ns / 1ps
interface cpa_req_if;
    logic                        valid;
    logic                        ready;
    logic                        req_type;
    logic [cpa_pkg::COUNT_W-1:0] page_count;
    logic [cpa_pkg::SPAGE_W-1:0] first_page;
    modport source (output valid, req_type, page_count, first_page, input ready);
    modport sink   (input valid, req_type, page_count, first_page, output ready);
endinterface

interface cpa_resp_if;
    logic                         valid;
    logic                         ready;
    logic [cpa_pkg::STATUS_W-1:0] status;
    logic [cpa_pkg::GRANT_W-1:0]  granted_page;
    modport source (output valid, status, granted_page, input ready);
    modport sink   (input valid, status, granted_page, output ready);
endinterface

// ----- sv/cpa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module cpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- sv/contiguous_page_allocator.sv -----
// Top level of the contiguous page allocator: sequencer and bitmap scan.
`timescale 1ns / 1ps
`include "contiguous_page_allocator_defines.svh"

// Contiguous page allocator. The used-page bitmap lives in a RAM of 8-bit words; one
// request is taken at a time and walked one page per clock by a single scan unit while a
// loaded word is scanned. A search fetches each 8-page word (fetch, then load) and then
// scans its pages; marking a granted run fetches each word touched, updates its bits and
// writes it back. A next-fit request that misses in a first pass that did not start at
// page 0 rescans from page 0. A free checks and then clears its run. A rejected request
// has its response valid on the cycle after the request transfer, and the block is ready
// again in the cycle after the response transfer. After reset a clearing pass zeroes the
// bitmap before the first request is taken; fit_mode writes are taken at any time.
module contiguous_page_allocator (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [cpa_pkg::FIT_W-1:0] i_cfg_wdata,
    cpa_req_if.sink                   i_req,
    cpa_resp_if.source                o_resp
);
    localparam logic [cpa_pkg::PTR_W-1:0] LAST_PAGE = cpa_pkg::PTR_W'(cpa_pkg::NUM_PAGES - 1);
    localparam logic [cpa_pkg::PTR_W-1:0] POOL_END  = cpa_pkg::PTR_W'(cpa_pkg::NUM_PAGES);
    localparam logic [cpa_pkg::WBIT_W-1:0] WORD_TOP = cpa_pkg::WBIT_W'(cpa_pkg::WORD_W - 1);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_FETCH, S_LOAD, S_SCAN, S_WRITE, S_RESP
    } t_state;

    typedef enum logic [1:0] {
        PH_SEARCH, PH_CHECK, PH_MARK
    } t_phase;

    t_state                         r_state;
    t_phase                         r_phase;
    logic [cpa_pkg::FIT_W-1:0]      r_fit;
    logic [cpa_pkg::PAGE_W-1:0]     r_rove;
    logic [cpa_pkg::WADDR_W-1:0]    r_clr;
    logic [cpa_pkg::WADDR_W-1:0]    r_widx;
    logic [cpa_pkg::WORD_W-1:0]     r_word;
    logic [cpa_pkg::PTR_W-1:0]      r_ptr;
    logic [cpa_pkg::PTR_W-1:0]      r_end;
    logic [cpa_pkg::PTR_W-1:0]      r_cnt;
    logic [cpa_pkg::PTR_W-1:0]      r_run;
    logic [cpa_pkg::PTR_W-1:0]      r_rs;
    logic [cpa_pkg::PTR_W-1:0]      r_best_len;
    logic [cpa_pkg::PTR_W-1:0]      r_best_st;
    logic                           r_best_ok;
    logic                           r_is_best;
    logic                           r_is_next;
    logic                           r_retry;
    logic                           r_mval;
    logic [cpa_pkg::STATUS_W-1:0]   r_status;
    logic [cpa_pkg::GRANT_W-1:0]    r_granted;

    logic [cpa_pkg::WORD_W-1:0]     ram_rdata;
    logic                           ram_we;
    logic [cpa_pkg::WADDR_W-1:0]    ram_waddr;
    logic [cpa_pkg::WORD_W-1:0]     ram_wdata;

    // Request range checks
    logic [cpa_pkg::CHK_W-1:0]      chk_cnt;
    logic [cpa_pkg::CHK_W-1:0]      chk_end;
    logic                           bad_alloc;
    logic                           bad_free;

    // Scan unit
    logic                           bit_v;
    logic                           last_page;
    logic                           word_end;
    logic [cpa_pkg::PTR_W-1:0]      ptr_inc;
    logic [cpa_pkg::PTR_W-1:0]      run_inc;
    logic                           found_free;
    logic [cpa_pkg::PTR_W-1:0]      free_idx;
    logic [cpa_pkg::PTR_W-1:0]      cur_len;
    logic [cpa_pkg::PTR_W-1:0]      cur_start;
    logic                           cand;
    logic                           exact;
    logic [cpa_pkg::PTR_W-1:0]      sel_idx;
    logic [cpa_pkg::PTR_W-1:0]      sel_end;
    logic [cpa_pkg::WORD_W-1:0]     n_word;

    cpa_ram #(
        .WIDTH (cpa_pkg::WORD_W),
        .DEPTH (cpa_pkg::NUM_WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_ptr[cpa_pkg::PAGE_W-1:cpa_pkg::WBIT_W]),
        .o_rdata (ram_rdata)
    );

    assign ram_we    = (r_state == S_CLEAR) || (r_state == S_WRITE);
    assign ram_waddr = (r_state == S_CLEAR) ? r_clr : r_widx;
    assign ram_wdata = (r_state == S_CLEAR) ? '0 : r_word;

    assign chk_cnt   = cpa_pkg::CHK_W'(i_req.page_count);
    assign chk_end   = cpa_pkg::CHK_W'(i_req.first_page) + chk_cnt;
    assign bad_alloc = (chk_cnt == '0) || (chk_cnt > cpa_pkg::CHK_W'(cpa_pkg::NUM_PAGES));
    assign bad_free  = (chk_cnt == '0) || (chk_end > cpa_pkg::CHK_W'(cpa_pkg::NUM_PAGES));

    // One page per cycle in the scan state: free-run tracking, best-fit candidate test, grant pick, marked word
    always_comb begin
        bit_v      = r_word[r_ptr[cpa_pkg::WBIT_W-1:0]];
        last_page  = (r_ptr == LAST_PAGE);
        word_end   = (r_ptr[cpa_pkg::WBIT_W-1:0] == WORD_TOP);
        ptr_inc    = r_ptr + 1'b1;
        run_inc    = r_run + 1'b1;
        found_free = !bit_v && (run_inc >= r_cnt);
        free_idx   = ptr_inc - r_cnt;
        cur_len    = bit_v ? r_run : run_inc;
        cur_start  = (r_run == '0) ? r_ptr : r_rs;
        cand       = (bit_v || last_page) && (cur_len != '0) && (cur_len >= r_cnt)
                     && (cur_len < r_best_len);
        exact      = cand && (cur_len == r_cnt);
        sel_idx    = r_is_best ? (cand ? cur_start : r_best_st) : free_idx;
        sel_end    = sel_idx + r_cnt;
        n_word     = r_word;
        n_word[r_ptr[cpa_pkg::WBIT_W-1:0]] = r_mval;
    end

    assign i_req.ready         = (r_state == S_IDLE);
    assign o_resp.valid        = (r_state == S_RESP);
    assign o_resp.status       = r_status;
    assign o_resp.granted_page = r_granted;

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_phase <= PH_SEARCH;
            r_fit   <= '0;
            r_rove  <= '0;
            r_clr   <= '0;
            r_retry <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_fit <= i_cfg_wdata;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == cpa_pkg::WADDR_W'(cpa_pkg::NUM_WORDS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_granted  <= '0;
                        r_cnt      <= cpa_pkg::PTR_W'(i_req.page_count);
                        r_run      <= '0;
                        r_best_len <= '1;
                        r_best_ok  <= 1'b0;
                        r_is_best  <= (r_fit == cpa_pkg::FIT_BEST);
                        r_is_next  <= (r_fit == cpa_pkg::FIT_NEXT);
                        if (i_req.req_type == cpa_pkg::REQ_FREE) begin
                            r_ptr    <= cpa_pkg::PTR_W'(i_req.first_page);
                            r_end    <= cpa_pkg::PTR_W'(chk_end);
                            r_phase  <= PH_CHECK;
                            r_status <= bad_free ? cpa_pkg::ST_RANGE : cpa_pkg::ST_OK;
                            r_state  <= bad_free ? S_RESP : S_FETCH;
                        end else begin
                            r_phase  <= PH_SEARCH;
                            r_ptr    <= (r_fit == cpa_pkg::FIT_NEXT)
                                        ? cpa_pkg::PTR_W'(r_rove) : '0;
                            r_retry  <= (r_fit == cpa_pkg::FIT_NEXT) && (r_rove != '0);
                            r_status <= bad_alloc ? cpa_pkg::ST_RANGE : cpa_pkg::ST_OK;
                            r_state  <= bad_alloc ? S_RESP : S_FETCH;
                        end
                    end
                end
                S_FETCH: begin
                    r_widx  <= r_ptr[cpa_pkg::PAGE_W-1:cpa_pkg::WBIT_W];
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_word  <= ram_rdata;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    case (r_phase)
                        PH_SEARCH: begin
                            // run tracking for the next page; a new pass starts empty
                            r_run <= (bit_v || last_page) ? '0 : run_inc;
                            if (!bit_v && r_run == '0) begin
                                r_rs <= r_ptr;
                            end
                            if (cand) begin
                                r_best_len <= cur_len;
                                r_best_st  <= cur_start;
                                r_best_ok  <= 1'b1;
                            end
                            if ((!r_is_best && found_free) || (r_is_best && exact)
                                || (r_is_best && last_page && (cand || r_best_ok))) begin
                                // grant: walk back over the run and mark it used
                                r_ptr     <= sel_idx;
                                r_end     <= sel_end;
                                r_mval    <= 1'b1;
                                r_phase   <= PH_MARK;
                                r_granted <= cpa_pkg::GRANT_W'(sel_idx);
                                if (r_is_next) begin
                                    r_rove <= (sel_end >= POOL_END)
                                              ? '0 : cpa_pkg::PAGE_W'(sel_end);
                                end
                                r_state <= S_FETCH;
                            end else if (last_page) begin
                                if (r_retry) begin
                                    r_retry <= 1'b0;
                                    r_ptr   <= '0;
                                    r_state <= S_FETCH;
                                end else begin
                                    r_status <= cpa_pkg::ST_NOFIT;
                                    r_state  <= S_RESP;
                                end
                            end else begin
                                r_ptr <= ptr_inc;
                                if (word_end) begin
                                    r_state <= S_FETCH;
                                end
                            end
                        end
                        PH_CHECK: begin
                            if (!bit_v) begin
                                r_status <= cpa_pkg::ST_NOTUSED;
                                r_state  <= S_RESP;
                            end else if (ptr_inc == r_end) begin
                                r_ptr   <= r_end - r_cnt;
                                r_mval  <= 1'b0;
                                r_phase <= PH_MARK;
                                r_state <= S_FETCH;
                            end else begin
                                r_ptr <= ptr_inc;
                                if (word_end) begin
                                    r_state <= S_FETCH;
                                end
                            end
                        end
                        PH_MARK: begin
                            r_word <= n_word;
                            r_ptr  <= ptr_inc;
                            if (word_end || ptr_inc == r_end) begin
                                r_state <= S_WRITE;
                            end
                        end
                        default: begin
                            r_state <= S_RESP;
                        end
                    endcase
                end
                S_WRITE: begin
                    r_state <= (r_ptr == r_end) ? S_RESP : S_FETCH;
                end
                S_RESP: begin
                    if (o_resp.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Checks
    `CPA_ASSERT_NOW(a_one_side, i_clk, i_rst_n, i_req.ready, !o_resp.valid,
        "request taken while a response is pending")
    `CPA_ASSERT_NOW(a_grant_zero, i_clk, i_rst_n,
        o_resp.valid && (o_resp.status != cpa_pkg::ST_OK), o_resp.granted_page == '0,
        "nonzero page on a failed request")
    `CPA_ASSERT_NEXT(a_back_idle, i_clk, i_rst_n, o_resp.valid && o_resp.ready, i_req.ready,
        "not ready after response transfer")
    `CPA_ASSERT_NOW(a_ptr_range, i_clk, i_rst_n, r_state == S_SCAN, r_ptr < POOL_END,
        "scan pointer past pool end")
endmodule

// ----- test/tb_contiguous_page_allocator.sv -----
// Self-checking testbench for the contiguous page allocator: predicted grants and status.
`timescale 1ns / 1ps

module tb_contiguous_page_allocator;
    localparam int          ITEMS_PER_MODE = 210;
    localparam int          NUM_MODES      = 6;
    localparam longint      CYCLE_LIMIT    = 15_000_000;
    localparam int          DRAIN_CYCLES   = 20;
    localparam int          NUM_PAGES      = cpa_pkg::NUM_PAGES;
    localparam logic        REQ_ALLOC      = 1'b0;
    localparam logic        REQ_FREE       = cpa_pkg::REQ_FREE;
    localparam logic [cpa_pkg::FIT_W-1:0] FIT_FIRST = 2'd0;
    localparam logic [cpa_pkg::FIT_W-1:0] FIT_NEXT  = cpa_pkg::FIT_NEXT;
    localparam logic [cpa_pkg::FIT_W-1:0] FIT_BEST  = cpa_pkg::FIT_BEST;
    localparam logic [cpa_pkg::FIT_W-1:0] FIT_ALT   = 2'd3;

    typedef struct packed {
        logic                        req_type;
        logic [cpa_pkg::COUNT_W-1:0] page_count;
        logic [cpa_pkg::SPAGE_W-1:0] first_page;
    } t_alloc_req;

    typedef struct packed {
        logic [cpa_pkg::STATUS_W-1:0] status;
        logic [cpa_pkg::GRANT_W-1:0]  granted_page;
    } t_alloc_resp;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [cpa_pkg::FIT_W-1:0] i_cfg_wdata;

    cpa_req_if  req_ch ();
    cpa_resp_if resp_ch ();

    contiguous_page_allocator uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_ch),
        .o_resp      (resp_ch)
    );

    // Predictor state
    bit                        page_used [NUM_PAGES];
    int                        rover;
    logic [cpa_pkg::FIT_W-1:0] fit_sel;
    int                        run_start [$];
    int                        run_len [$];

    t_alloc_req  pending_reqs [$];
    t_alloc_resp expected_resps [$];

    int     send_idle_pct;
    int     recv_idle_pct;
    int     mismatches;
    int     resp_count;
    int     status_seen [4];
    longint cycles;

    // Clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Lowest free run of cnt pages at or above from; -1 when none
    function automatic int scan_first(int from, int cnt);
        int run;
        run = 0;
        for (int i = from; i < NUM_PAGES; i++) begin
            if (page_used[i]) begin
                run = 0;
            end else begin
                run++;
                if (run >= cnt) return i + 1 - cnt;
            end
        end
        return -1;
    endfunction

    // Smallest free run that fits, earliest on ties, stopping on exact fit
    function automatic int scan_best(int cnt);
        int best, best_len, i, s, len;
        best = -1;
        best_len = NUM_PAGES + 1;
        i = 0;
        while (i < NUM_PAGES) begin
            if (page_used[i]) begin
                i++;
            end else begin
                s = i;
                len = 0;
                while (i < NUM_PAGES && !page_used[i]) begin
                    len++;
                    i++;
                end
                if (len >= cnt && len < best_len) begin
                    best = s;
                    best_len = len;
                    if (len == cnt) break;
                end
            end
        end
        return best;
    endfunction

    function automatic void forget_runs(int s, int cnt);
        for (int k = run_start.size() - 1; k >= 0; k--) begin
            if (run_start[k] < s + cnt && run_start[k] + run_len[k] > s) begin
                run_start.delete(k);
                run_len.delete(k);
            end
        end
    endfunction

    // Expected response for one accepted request; updates the predictor state
    function automatic t_alloc_resp predict_alloc(t_alloc_req r);
        t_alloc_resp res;
        int cnt, sp, idx;
        bit all_used;
        res = '0;
        cnt = r.page_count;
        sp = r.first_page;
        if (r.req_type == REQ_ALLOC) begin
            if (cnt == 0 || cnt > NUM_PAGES) begin
                res.status = cpa_pkg::ST_RANGE;
            end else begin
                if (fit_sel == FIT_NEXT) begin
                    idx = scan_first(rover, cnt);
                    if (idx < 0) idx = scan_first(0, cnt);
                end else if (fit_sel == FIT_BEST) begin
                    idx = scan_best(cnt);
                end else begin
                    idx = scan_first(0, cnt);
                end
                if (idx < 0) begin
                    res.status = cpa_pkg::ST_NOFIT;
                end else begin
                    for (int i = 0; i < cnt; i++) page_used[idx + i] = 1'b1;
                    if (fit_sel == FIT_NEXT)
                        rover = (idx + cnt >= NUM_PAGES) ? 0 : idx + cnt;
                    res.status = cpa_pkg::ST_OK;
                    res.granted_page = idx[cpa_pkg::GRANT_W-1:0];
                    run_start.push_back(idx);
                    run_len.push_back(cnt);
                end
            end
        end else begin
            if (cnt == 0 || sp + cnt > NUM_PAGES) begin
                res.status = cpa_pkg::ST_RANGE;
            end else begin
                all_used = 1'b1;
                for (int i = 0; i < cnt; i++) if (!page_used[sp + i]) all_used = 1'b0;
                if (!all_used) begin
                    res.status = cpa_pkg::ST_NOTUSED;
                end else begin
                    for (int i = 0; i < cnt; i++) page_used[sp + i] = 1'b0;
                    res.status = cpa_pkg::ST_OK;
                    forget_runs(sp, cnt);
                end
            end
        end
        return res;
    endfunction

    function automatic t_alloc_req mk_req(logic rt, int cnt, int sp);
        t_alloc_req r;
        r.req_type = rt;
        r.page_count = cnt[cpa_pkg::COUNT_W-1:0];
        r.first_page = sp[cpa_pkg::SPAGE_W-1:0];
        return r;
    endfunction

    function automatic int pages_in_use();
        int n;
        n = 0;
        foreach (page_used[i]) n += page_used[i];
        return n;
    endfunction

    // Random request, mostly allocations of small runs and frees of granted runs
    function automatic t_alloc_req random_req();
        int sel, k, off, len;
        sel = $urandom_range(99);
        if (sel < 6) begin
            // noise: any field values
            return mk_req(1'($urandom_range(1)), $urandom_range(2047), $urandom_range(1023));
        end
        if (run_start.size() > 0 && (sel < 45 || pages_in_use() > 700)) begin
            k = $urandom_range(run_start.size() - 1);
            if ($urandom_range(4) != 0) return mk_req(REQ_FREE, run_len[k], run_start[k]);
            off = $urandom_range(run_len[k] - 1);
            len = $urandom_range(run_len[k] - off + 1, 1);
            return mk_req(REQ_FREE, len, run_start[k] + off);
        end
        if ($urandom_range(29) == 0) return mk_req(REQ_ALLOC, $urandom_range(1024, 200), 0);
        return mk_req(REQ_ALLOC, $urandom_range(24, 1), $urandom_range(1023));
    endfunction

    // Request driver; predicts at each transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid      <= 1'b0;
            req_ch.req_type   <= 1'b0;
            req_ch.page_count <= '0;
            req_ch.first_page <= '0;
        end else if (!req_ch.valid || req_ch.ready) begin
            if (req_ch.valid) expected_resps.push_back(predict_alloc(
                mk_req(req_ch.req_type, req_ch.page_count, req_ch.first_page)));
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                t_alloc_req r;
                r = pending_reqs.pop_front();
                req_ch.valid      <= 1'b1;
                req_ch.req_type   <= r.req_type;
                req_ch.page_count <= r.page_count;
                req_ch.first_page <= r.first_page;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Response monitor and checker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            resp_ch.ready <= 1'b0;
        end else begin
            if (resp_ch.valid && resp_ch.ready) begin
                if (expected_resps.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: response with nothing expected: status %0d page %0d",
                                 resp_ch.status, resp_ch.granted_page);
                end else begin
                    t_alloc_resp e;
                    e = expected_resps.pop_front();
                    resp_count++;
                    status_seen[e.status]++;
                    if (resp_ch.status !== e.status
                        || resp_ch.granted_page !== e.granted_page) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"ERROR: response %0d: expected status %0d page %0d,",
                                      " got status %0d page %0d"},
                                     resp_count, e.status, e.granted_page,
                                     resp_ch.status, resp_ch.granted_page);
                    end
                end
            end
            resp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("contiguous_page_allocator test failed");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || req_ch.valid || expected_resps.size() > 0)
            @(posedge i_clk);
    endtask

    task automatic write_fit(logic [cpa_pkg::FIT_W-1:0] m);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        fit_sel = m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic push(logic rt, int cnt, int sp);
        pending_reqs.push_back(mk_req(rt, cnt, sp));
    endtask

    // Stimulus sequence
    initial begin
        logic [cpa_pkg::FIT_W-1:0] modes [NUM_MODES];
        int sent, batch;
        modes = '{FIT_FIRST, FIT_NEXT, FIT_BEST, FIT_ALT, FIT_NEXT, FIT_BEST};
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= '0;
        cycles = 0;
        mismatches = 0;
        resp_count = 0;
        rover = 0;
        fit_sel = FIT_FIRST;
        send_idle_pct = 10;
        recv_idle_pct = 85;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: range checks, full pool, not-used frees, best fit choice, next fit
        push(REQ_ALLOC, 0, 0);
        push(REQ_ALLOC, 1025, 0);
        push(REQ_ALLOC, 2047, 1023);
        push(REQ_FREE, 0, 0);
        push(REQ_FREE, 5, 1);
        push(REQ_ALLOC, 1024, 0);
        push(REQ_ALLOC, 1, 0);
        push(REQ_FREE, 2, 1023);
        push(REQ_FREE, 1024, 0);
        push(REQ_FREE, 1, 1023);
        push(REQ_ALLOC, 10, 0);
        push(REQ_ALLOC, 3, 0);
        push(REQ_ALLOC, 20, 0);
        push(REQ_ALLOC, 3, 0);
        push(REQ_FREE, 10, 0);
        push(REQ_FREE, 3, 33);
        wait_drained();
        write_fit(FIT_BEST);
        push(REQ_ALLOC, 2, 0);
        push(REQ_ALLOC, 3, 0);
        push(REQ_ALLOC, 1000, 0);
        wait_drained();
        write_fit(FIT_NEXT);
        push(REQ_ALLOC, 4, 0);
        push(REQ_ALLOC, 980, 0);
        push(REQ_ALLOC, 5, 0);
        wait_drained();
        push(REQ_FREE, 1024 - 36, 36);
        wait_drained();

        // Random phases across fit modes and idle patterns
        for (int p = 0; p < NUM_MODES; p++) begin
            send_idle_pct = (p < 2) ? 10 : (p < 4) ? 85 : 0;
            recv_idle_pct = (p < 2) ? 85 : (p < 4) ? 10 : 0;
            repeat (DRAIN_CYCLES) @(posedge i_clk);
            write_fit(modes[p]);
            sent = 0;
            while (sent < ITEMS_PER_MODE) begin
                // requests built from the state after the previous burst drained
                batch = $urandom_range(12, 1);
                for (int k = 0; k < batch; k++) pending_reqs.push_back(random_req());
                sent += batch;
                wait_drained();
            end
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Checked %0d responses over fit modes 0..3 and three idle patterns.",
                 resp_count);
        $display("Status counts: ok %0d, no fit %0d, range %0d, not used %0d.",
                 status_seen[cpa_pkg::ST_OK], status_seen[cpa_pkg::ST_NOFIT],
                 status_seen[cpa_pkg::ST_RANGE], status_seen[cpa_pkg::ST_NOTUSED]);
        if (mismatches == 0 && expected_resps.size() == 0) begin
            $display("contiguous_page_allocator test passed");
        end else begin
            $display("%0d mismatches, %0d responses missing", mismatches, expected_resps.size());
            $display("contiguous_page_allocator test failed");
        end
        $finish;
    end
endmodule
